@@ sv/serial_command_line_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Serial command line parser: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH

// Condition in this cycle implies the consequence in the same cycle.
`define SCLP_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("sclp assertion failed");

// Condition in this cycle implies the consequence in the next cycle.
`define SCLP_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("sclp assertion failed");

`endif

@@ sv/sclp_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial command line parser package
// Match states, status codes, byte constants and the per-byte match function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sclp_pkg;

  localparam int LINE_BYTES = 64;
  localparam int MAX_LEN    = LINE_BYTES - 1;
  localparam int LEN_W      = $clog2(LINE_BYTES);

  localparam logic [31:0] MIN_RATE_RESET = 32'd100;
  localparam logic [31:0] PERIOD_RESET   = 32'd1000;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [3:0] {
    MS_EMPTY, MS_S, MS_ST, MS_STA, MS_STAR, MS_START, MS_STO, MS_STOP,
    MS_R, MS_RA, MS_RAT, MS_RATE, MS_ARG, MS_ARG_BAD, MS_NONE
  } match_t;

  typedef enum logic [2:0] {
    ST_START, ST_STOP, ST_RATE_SET, ST_RATE_LOW, ST_RATE_BAD, ST_UNKNOWN
  } status_t;

  // Summary of a finished line that produces a result.
  typedef struct packed {
    logic        fire;
    match_t      ms;
    logic        digits_seen;
    logic [31:0] acc;
  } line_evt_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic match_t next_match(input match_t s, input logic [7:0] c);
    match_t ns;
    ns = MS_NONE;
    unique case (s)
      MS_EMPTY:   ns = (c == CH_S) ? MS_S : ((c == CH_R) ? MS_R : MS_NONE);
      MS_S:       ns = (c == CH_T) ? MS_ST : MS_NONE;
      MS_ST:      ns = (c == CH_A) ? MS_STA : ((c == CH_O) ? MS_STO : MS_NONE);
      MS_STA:     ns = (c == CH_R) ? MS_STAR : MS_NONE;
      MS_STAR:    ns = (c == CH_T) ? MS_START : MS_NONE;
      MS_STO:     ns = (c == CH_P) ? MS_STOP : MS_NONE;
      MS_R:       ns = (c == CH_A) ? MS_RA : MS_NONE;
      MS_RA:      ns = (c == CH_T) ? MS_RAT : MS_NONE;
      MS_RAT:     ns = (c == CH_E) ? MS_RATE : MS_NONE;
      MS_RATE:    ns = (c == CH_SPACE) ? MS_ARG : MS_NONE;
      MS_ARG:     ns = is_digit(c) ? MS_ARG : MS_ARG_BAD;
      MS_ARG_BAD: ns = MS_ARG_BAD;
      default:    ns = MS_NONE;
    endcase
    return ns;
  endfunction

endpackage

`default_nettype wire

@@ sv/sclp_line.sv @@
// ----------------------------------------------------------------------------
// Serial command line parser: line tracker
// Counts the bytes of the current line, runs the command matcher and the
// saturating decimal accumulator, and reports a finished, usable line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sclp_line (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            rx_byte,
  output sclp_pkg::line_evt_t        evt
);
  import sclp_pkg::*;

  logic [LEN_W-1:0] line_length;
  logic             line_overflowed;
  match_t           match_state;
  logic             text_ended;
  logic [31:0]      digit_acc;
  logic             digits_seen;

  logic             is_term;
  logic             line_full;
  match_t           ms_next;
  logic [35:0]      acc_wide;
  logic [31:0]      acc_sat;

  assign is_term   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign line_full = (line_length == LEN_W'(MAX_LEN));
  assign ms_next   = next_match(match_state, rx_byte);

  // acc * 10 + digit, clamped to the 32-bit range.
  assign acc_wide = ({4'b0, digit_acc} << 3) + ({4'b0, digit_acc} << 1)
                  + {32'b0, rx_byte[3:0]};
  assign acc_sat  = (|acc_wide[35:32]) ? 32'hFFFF_FFFF : acc_wide[31:0];

  always_comb begin
    evt.fire        = accept && is_term && (line_length != '0) && !line_overflowed;
    evt.ms          = match_state;
    evt.digits_seen = digits_seen;
    evt.acc         = digit_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      line_overflowed <= 1'b0;
      match_state     <= MS_EMPTY;
      text_ended      <= 1'b0;
      digit_acc       <= '0;
      digits_seen     <= 1'b0;
    end else if (accept) begin
      if (is_term) begin
        // Every line end clears the line, whether or not it gave a result.
        line_length     <= '0;
        line_overflowed <= 1'b0;
        match_state     <= MS_EMPTY;
        text_ended      <= 1'b0;
        digit_acc       <= '0;
        digits_seen     <= 1'b0;
      end else if (line_full) begin
        line_overflowed <= 1'b1;
      end else begin
        line_length <= line_length + LEN_W'(1);
        if (!text_ended) begin
          if (rx_byte == CH_NUL) begin
            text_ended <= 1'b1;
          end else begin
            if ((match_state == MS_ARG) && (ms_next == MS_ARG)) begin
              digit_acc   <= acc_sat;
              digits_seen <= 1'b1;
            end
            match_state <= ms_next;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/serial_command_line_parser.sv @@
// ----------------------------------------------------------------------------
// Serial command line parser
// A result is loaded into the output register at the end of the cycle that
// transfers the CR or LF byte ending its line.
// Throughput: one byte per cycle; input stalls only while a held result is
// stalled.
// Reset: synchronous; logging off, period 1000 ms, minimum rate 100 ms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "serial_command_line_parser_defines.svh"

module serial_command_line_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        min_rate_we,
  input  wire logic [31:0] min_rate_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      rate_value,
  output logic             logging_on,
  output logic [31:0]      sample_period_ms
);
  import sclp_pkg::*;

  logic        in_accept;
  line_evt_t   evt;

  logic [31:0] min_rate;
  logic        enable_flag;
  logic [31:0] period;

  status_t     status_next;
  logic [31:0] rate_next;
  logic        enable_next;
  logic [31:0] period_next;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  sclp_line u_line (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .evt     (evt)
  );

  always_comb begin
    status_next = ST_UNKNOWN;
    rate_next   = '0;
    enable_next = enable_flag;
    period_next = period;
    unique case (evt.ms)
      MS_START: begin
        enable_next = 1'b1;
        status_next = ST_START;
      end
      MS_STOP: begin
        enable_next = 1'b0;
        status_next = ST_STOP;
      end
      MS_ARG: begin
        if (evt.digits_seen) begin
          rate_next = evt.acc;
          if (evt.acc >= min_rate) begin
            period_next = evt.acc;
            status_next = ST_RATE_SET;
          end else begin
            status_next = ST_RATE_LOW;
          end
        end else begin
          status_next = ST_RATE_BAD;
        end
      end
      MS_ARG_BAD: status_next = ST_RATE_BAD;
      default:    status_next = ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate    <= MIN_RATE_RESET;
      enable_flag <= 1'b0;
      period      <= PERIOD_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (min_rate_we) begin
        min_rate <= min_rate_data;
      end
      if (evt.fire) begin
        enable_flag <= enable_next;
        period      <= period_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only when the output register is free.
  always_ff @(posedge clk) begin
    if (evt.fire) begin
      status           <= status_next;
      rate_value       <= rate_next;
      logging_on       <= enable_next;
      sample_period_ms <= period_next;
    end
  end

  `SCLP_ASSERT_NOW(a_stall_only_when_held, clk, rst, in_stall, out_valid)
  `SCLP_ASSERT_NOW(a_status_in_range, clk, rst, out_valid, status <= ST_UNKNOWN)
  `SCLP_ASSERT_NOW(a_start_enables, clk, rst, out_valid && (status == ST_START), logging_on)
  `SCLP_ASSERT_NOW(a_rate_zero_else, clk, rst,
    out_valid && (status != ST_RATE_SET) && (status != ST_RATE_LOW), rate_value == '0)
  `SCLP_ASSERT_NOW(a_rate_set_period, clk, rst,
    out_valid && (status == ST_RATE_SET), sample_period_ms == rate_value)
  `SCLP_ASSERT_NEXT(a_fire_gives_result, clk, rst, evt.fire, out_valid)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line parser testbench
// Streams received bytes into the parser and checks each command result
// against a typed-in result or a byte-level predictor. Hand-picked lines
// come first, most with their results typed in; random lines follow under
// several minimum-rate settings and idle patterns, with one long output hold.
// ----------------------------------------------------------------------------

module testbench;
  import sclp_pkg::*;

  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam int          SEG_BYTES   = 250;
  localparam int          LONG_HOLD   = 400;
  localparam int          STALL_LIMIT = 4000;

  localparam logic [39:0] WORD_START = {CH_S, CH_T, CH_A, CH_R, CH_T};
  localparam logic [31:0] WORD_STOP  = {CH_S, CH_T, CH_O, CH_P};
  localparam logic [39:0] WORD_RATE  = {CH_R, CH_A, CH_T, CH_E, CH_SPACE};

  typedef struct packed {
    status_t     st;
    logic [31:0] rate;
    logic        logging;
    logic [31:0] period;
  } cmd_result_t;

  typedef struct packed {
    logic        typed;
    logic        fires;
    cmd_result_t want;
  } note_t;

  typedef struct packed {
    logic [7:0] fill;
    logic [7:0] pad;
    logic [7:0] term;
    note_t      note;
  } shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        min_rate_we = 1'b0;
  logic [31:0] min_rate_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] rate_value;
  logic        logging_on;
  logic [31:0] sample_period_ms;

  serial_command_line_parser dut (
    .clk              (clk),
    .rst              (rst),
    .min_rate_we      (min_rate_we),
    .min_rate_data    (min_rate_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .rate_value       (rate_value),
    .logging_on       (logging_on),
    .sample_period_ms (sample_period_ms)
  );

  // Predictor state: one line in flight plus the persistent command state.
  logic [31:0] min_floor   = MIN_RATE_RESET;
  logic [31:0] period_now  = PERIOD_RESET;
  logic        logging_now = 1'b0;
  int          held_len    = 0;
  int          text_pos    = 0;
  bit          line_spilled = 1'b0;
  bit          text_done    = 1'b0;
  bit          arg_broken   = 1'b0;
  bit          have_digits  = 1'b0;
  bit          start_alive  = 1'b1;
  bit          stop_alive   = 1'b1;
  bit          rate_alive   = 1'b1;
  logic [31:0] digit_total  = '0;

  cmd_result_t command_replies[$];
  note_t       line_notes[$];
  logic [7:0]  outgoing[$];
  string       row_head[$];
  string       row_tail[$];
  shape_t      row_shape[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit squeeze_req   = 1'b0;
  bit squeeze_done  = 1'b0;
  int quiet_cycles  = 0;
  int failures      = 0;
  int bytes_sent    = 0;
  int lines_sent    = 0;
  int replies_seen  = 0;
  int settings_used = 1;
  int status_tally[6];

  initial forever #2 clk = ~clk;

  // Each keyword is tracked as a still-possible prefix; bytes past the
  // "RATE " prefix feed the decimal argument.
  function automatic bit parse_rx_byte(input logic [7:0] b, output cmd_result_t reply);
    logic [63:0] wide;
    bit          fired;
    reply.st   = ST_UNKNOWN;
    reply.rate = '0;
    fired      = 1'b0;
    if (b != CH_CR && b != CH_LF) begin
      if (held_len == MAX_LEN) begin
        line_spilled = 1'b1;
      end else begin
        held_len++;
        if (b == CH_NUL) begin
          text_done = 1'b1;
        end else if (!text_done) begin
          if (text_pos < 5) begin
            start_alive &= (b == WORD_START[8*(4-text_pos) +: 8]);
            rate_alive  &= (b == WORD_RATE[8*(4-text_pos) +: 8]);
          end else begin
            start_alive = 1'b0;
            if (rate_alive && !arg_broken) begin
              if (b >= CH_0 && b <= CH_9) begin
                wide = {32'd0, digit_total} * 64'd10 + {56'd0, b - CH_0};
                digit_total = (wide > {32'd0, ALL_ONES}) ? ALL_ONES : wide[31:0];
                have_digits = 1'b1;
              end else begin
                arg_broken = 1'b1;
              end
            end
          end
          if (text_pos < 4) stop_alive &= (b == WORD_STOP[8*(3-text_pos) +: 8]);
          else stop_alive = 1'b0;
          text_pos++;
        end
      end
    end else begin
      fired = (held_len != 0) && !line_spilled;
      if (fired) begin
        if (start_alive && text_pos == 5) begin
          logging_now = 1'b1;
          reply.st = ST_START;
        end else if (stop_alive && text_pos == 4) begin
          logging_now = 1'b0;
          reply.st = ST_STOP;
        end else if (rate_alive && text_pos >= 5) begin
          if (arg_broken || !have_digits) begin
            reply.st = ST_RATE_BAD;
          end else begin
            reply.rate = digit_total;
            if (digit_total >= min_floor) begin
              period_now = digit_total;
              reply.st = ST_RATE_SET;
            end else begin
              reply.st = ST_RATE_LOW;
            end
          end
        end
      end
      held_len     = 0;
      text_pos     = 0;
      line_spilled = 1'b0;
      text_done    = 1'b0;
      arg_broken   = 1'b0;
      have_digits  = 1'b0;
      start_alive  = 1'b1;
      stop_alive   = 1'b1;
      rate_alive   = 1'b1;
      digit_total  = '0;
    end
    reply.logging = logging_now;
    reply.period  = period_now;
    return fired;
  endfunction

  function automatic void log_failure(input string what);
    failures++;
    if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) log_failure($sformatf("%s expected %0d, got %0d", field, want, got));
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) outgoing.push_back(s[i]);
  endfunction

  function automatic void add_row(input string head, input int fill, input logic [7:0] pad,
                                  input string tail, input logic [7:0] term,
                                  input bit typed = 1'b0, input bit fires = 1'b0,
                                  input status_t st = ST_UNKNOWN,
                                  input logic [31:0] rate = '0, input bit log_on = 1'b0,
                                  input logic [31:0] period = '0);
    shape_t shape;
    shape.fill              = fill[7:0];
    shape.pad               = pad;
    shape.term              = term;
    shape.note.typed        = typed;
    shape.note.fires        = fires;
    shape.note.want.st      = st;
    shape.note.want.rate    = rate;
    shape.note.want.logging = log_on;
    shape.note.want.period  = period;
    row_head.push_back(head);
    row_tail.push_back(tail);
    row_shape.push_back(shape);
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic string rate_digits();
    logic [31:0] v;
    string       s;
    v = '0;
    s = "";
    case ($urandom_range(6))
      0: v = min_floor;
      1: v = (min_floor == 0) ? '0 : min_floor - 1;
      2: v = (min_floor == ALL_ONES) ? ALL_ONES : min_floor + 1;
      3: v = $urandom;
      4: v = $urandom_range(3000);
      5: v = $urandom_range(9);
      default: repeat ($urandom_range(11, 20)) s = {s, $sformatf("%0d", $urandom_range(9))};
    endcase
    if (s.len() == 0) s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = {"00", s};
    return s;
  endfunction

  // Mostly well-formed commands; the rest are corrupted, cut short,
  // zero-terminated early, pure noise, over-long or empty.
  task automatic compose_line();
    int kind;
    int spot;
    int n;
    kind = $urandom_range(99);
    outgoing.delete();
    case ($urandom_range(2))
      0:       push_text("START");
      1:       push_text("STOP");
      default: push_text({"RATE ", rate_digits()});
    endcase
    if (kind >= 66 && kind < 76) begin
      spot = $urandom_range(outgoing.size() - 1);
      outgoing[spot] = stray_byte();
    end else if (kind >= 76 && kind < 84) begin
      spot = $urandom_range(outgoing.size());
      outgoing.insert(spot, CH_NUL);
      repeat ($urandom_range(3)) outgoing.push_back(stray_byte());
    end else if (kind >= 84 && kind < 90) begin
      n = $urandom_range(1, outgoing.size());
      repeat (n) void'(outgoing.pop_back());
    end else if (kind >= 90 && kind < 95) begin
      outgoing.delete();
      repeat ($urandom_range(1, 12)) outgoing.push_back(stray_byte());
    end else if (kind >= 95 && kind < 98) begin
      n = $urandom_range(58, 70);
      while (outgoing.size() < n)
        outgoing.push_back(($urandom_range(3) == 0) ? stray_byte() : CH_NUL);
    end else if (kind >= 98) begin
      outgoing.delete();
    end
    outgoing.push_back($urandom_range(1) ? CH_CR : CH_LF);
    if ($urandom_range(9) == 0) outgoing.push_back(CH_LF);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_outgoing();
    foreach (outgoing[i]) send_byte(outgoing[i]);
    lines_sent++;
  endtask

  // The register may only change while the parser is idle, so drain first.
  task automatic settle_and_set(input logic [31:0] floor_value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (command_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    min_rate_we   <= 1'b1;
    min_rate_data <= floor_value;
    min_floor = floor_value;
    @(posedge clk);
    min_rate_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        squeeze_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin : port_monitor
    cmd_result_t guess;
    cmd_result_t want;
    note_t       note;
    bit          fired;
    if (!rst && in_valid && !in_stall) begin
      fired = parse_rx_byte(rx_byte, guess);
      if ((rx_byte == CH_CR || rx_byte == CH_LF) && line_notes.size() != 0) begin
        note = line_notes.pop_front();
        if (note.typed) begin
          fired = note.fires;
          guess = note.want;
        end
      end
      if (fired) command_replies.push_back(guess);
    end
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (status <= ST_UNKNOWN) status_tally[status]++;
      if (command_replies.size() == 0) begin
        log_failure($sformatf("result with none pending, status %0d", status));
      end else begin
        want = command_replies.pop_front();
        check_field("status", want.st, status);
        check_field("rate_value", want.rate, rate_value);
        check_field("logging_on", want.logging, logging_on);
        check_field("sample_period_ms", want.period, sample_period_ms);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("serial_command_line_parser regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] floors [6];
    int          seg_start;

    // Lines from reset: minimum 100, logging off, period 1000.
    add_row("START", 0, CH_NUL, "", CH_LF, 1, 1, ST_START, 0, 1, PERIOD_RESET);
    add_row("STOP", 0, CH_NUL, "", CH_CR, 1, 1, ST_STOP, 0, 0, PERIOD_RESET);
    add_row("RATE 100", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_SET, 100, 0, 100);
    add_row("RATE 99", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_LOW, 99, 0, 100);
    add_row("RATE ", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_BAD, 0, 0, 100);
    add_row("RATE 12a3", 0, CH_NUL, "", CH_CR, 1, 1, ST_RATE_BAD, 0, 0, 100);
    add_row("RATE 99999999999", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_SET, ALL_ONES, 0, ALL_ONES);
    add_row("RATE 4294967295", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_SET, ALL_ONES, 0, ALL_ONES);
    add_row("RATE 0", 0, CH_NUL, "", CH_LF, 1, 1, ST_RATE_LOW, 0, 0, ALL_ONES);
    add_row("", 0, CH_NUL, "", CH_LF, 1, 0);
    add_row("STAR", 0, CH_NUL, "", CH_LF, 1, 1, ST_UNKNOWN, 0, 0, ALL_ONES);
    add_row("START ", 0, CH_NUL, "", CH_LF, 1, 1, ST_UNKNOWN, 0, 0, ALL_ONES);
    add_row("start", 0, CH_NUL, "", CH_CR, 1, 1, ST_UNKNOWN, 0, 0, ALL_ONES);
    add_row("", 1, CH_NUL, "START", CH_LF, 1, 1, ST_UNKNOWN, 0, 0, ALL_ONES);
    add_row("START", 1, CH_NUL, "XYZ", CH_LF, 1, 1, ST_START, 0, 1, ALL_ONES);
    // A line of exactly 63 bytes still counts; one byte more drops it.
    add_row("STOP", 59, CH_NUL, "", CH_LF, 1, 1, ST_STOP, 0, 0, ALL_ONES);
    add_row("START", 59, CH_NUL, "", CH_CR, 1, 0);
    add_row("START", 0, CH_NUL, "", CH_CR, 1, 1, ST_START, 0, 1, ALL_ONES);
    add_row("RATE 000000000000000250", 0, CH_NUL, "", CH_LF);
    add_row("RATE 4294967296", 0, CH_NUL, "", CH_LF);
    add_row("", 3, 8'hFF, "", CH_LF);
    add_row("RATE 5 ", 0, CH_NUL, "", CH_CR);
    add_row("RATEX", 0, CH_NUL, "", CH_LF);
    add_row("RATE  5", 0, CH_NUL, "", CH_LF);
    add_row("STOPS", 0, CH_NUL, "", CH_CR);

    floors[0] = '0;
    floors[1] = ALL_ONES;
    floors[2] = $urandom_range(1, 5000);
    floors[3] = $urandom;
    floors[4] = 32'd1;
    floors[5] = MIN_RATE_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 37;
    sink_idle_pct = 66;
    foreach (row_shape[r]) begin
      outgoing.delete();
      push_text(row_head[r]);
      repeat (row_shape[r].fill) outgoing.push_back(row_shape[r].pad);
      push_text(row_tail[r]);
      outgoing.push_back(row_shape[r].term);
      line_notes.push_back(row_shape[r].note);
      send_outgoing();
    end

    for (int seg = 0; seg < 6; seg++) begin
      settle_and_set(floors[seg]);
      src_idle_pct  = (seg < 2) ? 37 : ((seg < 4) ? 66 : 0);
      sink_idle_pct = (seg < 2) ? 66 : ((seg < 4) ? 37 : 0);
      // Hold the output off while bytes keep coming so the input backs up.
      if (seg == 5) squeeze_req = 1'b1;
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEG_BYTES) begin
        compose_line();
        send_outgoing();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (command_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (command_replies.size() != 0)
      log_failure($sformatf("%0d results never arrived", command_replies.size()));

    $display("Sent %0d bytes in %0d lines under %0d minimum-rate settings; %0d results checked.",
             bytes_sent, lines_sent, settings_used, replies_seen);
    $display("Results by status: start %0d, stop %0d, set %0d, low %0d, malformed %0d, unknown %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (failures == 0) begin
      $display("serial_command_line_parser regression: pass");
    end else begin
      $display("Failures: %0d", failures);
      $display("serial_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
